[rtl/pfd_pkg.sv]
`timescale 1ns / 1ps

package pfd_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int KEEP_W   = 17;
    localparam int LIMIT_W  = 23;
    localparam int STATE_W  = 32;
    localparam int PWM_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Limit after reset: 9.4248 in Q8.16.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd617664;

    // PWM scale: 21.25 = 85 / 4, applied to a Q8.16 command.
    localparam int PWM_MUL   = 85;
    localparam int PWM_SHIFT = 18;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I_STEP = 3'd1,
        REG_DERIV_KEEP  = 3'd2,
        REG_DERIV_GAIN  = 3'd3,
        REG_LAST_STAGE  = 3'd4,
        REG_LIMIT       = 3'd5
    } cfg_reg_t;

    // Saturate a 36-bit signed value to 32-bit signed.
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [STATE_W-1:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
        begin
            r = v[31:0];
        end
        else
        begin
            r = {v[35], {(STATE_W-1){~v[35]}}};
        end
        return r;
    endfunction

endpackage

[rtl/pid_filtered_derivative.sv]
`timescale 1ns / 1ps

// PID controller with a first-order filtered derivative on the measurement.
// Samples enter on the sample channel (setpoint, feedback in signed Q8.16)
// and leave on the result channel (command, drive_pwm, emergency_stop).
// A request moves on a channel at a rising edge where valid is high and
// stall is low. Coefficients are written through cfg_write/cfg_index/cfg_data
// while no sample is in flight; indexes past the register list are ignored.
// The datapath has four register levels: input, products, sums and output.
// A new sample can be taken every cycle while sample_stall is low; the
// integrator and derivative filter loop closes in the sum stage, one
// multiply and two adds wide.
// When the receiver stalls, the output holds its result and the stages behind
// it keep filling; sample_stall rises only once every stage holds a request.
// Reset clears the integrator, the derivative filter, the stored feedback,
// all gains and last_stage, loads the limit with 9.4248, and empties the
// pipeline.
module pid_filtered_derivative
    import pfd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [SAMPLE_W-1:0]   setpoint,
    input  logic signed [SAMPLE_W-1:0]   feedback,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [SAMPLE_W-1:0]   command,
    output logic signed [PWM_W-1:0]      drive_pwm,
    output logic                         emergency_stop
);

    // Configuration registers.
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_step_reg;
    logic [KEEP_W-1:0]         deriv_keep_reg;
    logic signed [GAIN_W-1:0]  deriv_gain_reg;
    logic                      last_stage_reg;
    logic [LIMIT_W-1:0]        limit_reg;

    // Controller state.
    logic signed [STATE_W-1:0]  integral_reg;
    logic signed [STATE_W-1:0]  deriv_term_reg;
    logic signed [SAMPLE_W-1:0] prev_feedback_reg;

    // Pipeline registers.
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_setpoint_reg;
    logic signed [SAMPLE_W-1:0] s1_feedback_reg;
    logic                       s2_valid_reg;
    logic signed [48:0]         s2_prod_p_reg;
    logic signed [48:0]         s2_prod_i_reg;
    logic signed [48:0]         s2_prod_d_reg;
    logic signed [SAMPLE_W-1:0] s2_feedback_reg;
    logic                       s3_valid_reg;
    logic signed [STATE_W-1:0]  s3_sum_reg;
    logic signed [SAMPLE_W-1:0] s3_feedback_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_command_reg;
    logic signed [PWM_W-1:0]    out_pwm_reg;
    logic                       out_estop_reg;

    // Flow control: each stage takes a request when it is empty or moving on.
    logic out_take;
    logic s3_take;
    logic s2_take;
    logic s1_take;
    logic s1_move;
    logic s2_move;

    assign out_take     = !out_valid_reg || !result_stall;
    assign s3_take      = !s3_valid_reg || out_take;
    assign s2_take      = !s2_valid_reg || s3_take;
    assign s1_take      = !s1_valid_reg || s2_take;
    assign s1_move      = s1_valid_reg && s2_take;
    assign s2_move      = s2_valid_reg && s3_take;
    assign sample_stall = !s1_take;

    // Stage 1: error, feedback step against the stored feedback, and the three products.
    logic signed [24:0] err;
    logic signed [24:0] dy;
    logic signed [48:0] prod_p_next;
    logic signed [48:0] prod_i_next;
    logic signed [48:0] prod_d_next;

    assign err = {s1_setpoint_reg[SAMPLE_W-1], s1_setpoint_reg}
               - {s1_feedback_reg[SAMPLE_W-1], s1_feedback_reg};
    assign dy  = {s1_feedback_reg[SAMPLE_W-1], s1_feedback_reg}
               - {prev_feedback_reg[SAMPLE_W-1], prev_feedback_reg};
    assign prod_p_next = gain_p_reg * err;
    assign prod_i_next = gain_i_step_reg * err;
    assign prod_d_next = deriv_gain_reg * dy;

    // Stage 2: rounding, integrator and derivative filter, command sum.
    logic signed [49:0]        p_round;
    logic signed [49:0]        i_round;
    logic signed [STATE_W-1:0] up_sat;
    logic signed [35:0]        int_sum;
    logic signed [STATE_W-1:0] integral_next;
    logic signed [49:0]        keep_prod;
    logic signed [50:0]        d_diff;
    logic signed [50:0]        d_round;
    logic signed [STATE_W-1:0] deriv_term_next;
    logic signed [35:0]        u_sum;
    logic signed [STATE_W-1:0] sum_next;

    assign p_round = {s2_prod_p_reg[48], s2_prod_p_reg} + 50'sd32768;
    assign i_round = {s2_prod_i_reg[48], s2_prod_i_reg} + 50'sd32768;
    assign up_sat  = sat32({{2{p_round[49]}}, p_round[49:16]});
    assign int_sum = {{4{integral_reg[STATE_W-1]}}, integral_reg}
                   + {{2{i_round[49]}}, i_round[49:16]};
    assign integral_next = sat32(int_sum);

    assign keep_prod = $signed({1'b0, deriv_keep_reg}) * deriv_term_reg;
    assign d_diff    = {keep_prod[49], keep_prod}
                     - {{2{s2_prod_d_reg[48]}}, s2_prod_d_reg};
    assign d_round   = d_diff + 51'sd32768;
    assign deriv_term_next = sat32({d_round[50], d_round[50:16]});

    assign u_sum = {{4{up_sat[STATE_W-1]}}, up_sat}
                 + {{4{integral_next[STATE_W-1]}}, integral_next}
                 + {{4{deriv_term_next[STATE_W-1]}}, deriv_term_next};
    assign sum_next = sat32(u_sum);

    // Stage 3: feedback check, mode-dependent clamp and PWM scaling.
    logic signed [24:0]         lim25;
    logic signed [24:0]         fb25;
    logic                       fb_outside;
    logic signed [STATE_W-1:0]  lim32;
    logic signed [STATE_W-1:0]  neg_lim32;
    logic signed [SAMPLE_W-1:0] cmd_full;
    logic signed [SAMPLE_W-1:0] command_next;
    logic signed [31:0]         pwm_prod;
    logic signed [31:0]         pwm_round;
    logic signed [PWM_W-1:0]    pwm_next;
    logic                       estop_next;

    assign lim25      = $signed({2'b00, limit_reg});
    assign fb25       = {s3_feedback_reg[SAMPLE_W-1], s3_feedback_reg};
    assign fb_outside = (fb25 < -lim25) || (fb25 > lim25);
    assign lim32      = $signed({{(STATE_W-LIMIT_W){1'b0}}, limit_reg});
    assign neg_lim32  = -lim32;

    always_comb
    begin
        // Full 24-bit range clamp used by the last stage.
        if (s3_sum_reg > 32'sd8388607)
        begin
            cmd_full = 24'sh7FFFFF;
        end
        else if (s3_sum_reg < -32'sd8388608)
        begin
            cmd_full = 24'sh800000;
        end
        else
        begin
            cmd_full = s3_sum_reg[SAMPLE_W-1:0];
        end

        estop_next = 1'b0;
        if (last_stage_reg)
        begin
            if (fb_outside)
            begin
                command_next = '0;
                estop_next   = 1'b1;
            end
            else
            begin
                command_next = cmd_full;
            end
        end
        else if (s3_sum_reg > lim32)
        begin
            command_next = lim32[SAMPLE_W-1:0];
        end
        else if (s3_sum_reg < neg_lim32)
        begin
            command_next = neg_lim32[SAMPLE_W-1:0];
        end
        else
        begin
            command_next = s3_sum_reg[SAMPLE_W-1:0];
        end
    end

    // The scaled command stays within 14 signed bits, so no saturation is needed.
    assign pwm_prod  = {{(32-SAMPLE_W){command_next[SAMPLE_W-1]}}, command_next}
                     * 32'(PWM_MUL);
    assign pwm_round = pwm_prod + 32'sd131072;
    assign pwm_next  = last_stage_reg
                     ? {{2{pwm_round[31]}}, pwm_round[31:PWM_SHIFT]}
                     : '0;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= '0;
            gain_i_step_reg <= '0;
            deriv_keep_reg  <= '0;
            deriv_gain_reg  <= '0;
            last_stage_reg  <= 1'b0;
            limit_reg       <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P:      gain_p_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I_STEP: gain_i_step_reg <= cfg_data[GAIN_W-1:0];
                REG_DERIV_KEEP:  deriv_keep_reg  <= cfg_data[KEEP_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_LAST_STAGE:  last_stage_reg  <= cfg_data[0];
                REG_LIMIT:       limit_reg       <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Controller state advances as each request passes its stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_feedback_reg <= '0;
            integral_reg      <= '0;
            deriv_term_reg    <= '0;
        end
        else
        begin
            if (s1_move)
            begin
                prev_feedback_reg <= s1_feedback_reg;
            end
            if (s2_move)
            begin
                integral_reg   <= integral_next;
                deriv_term_reg <= deriv_term_next;
            end
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_take)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_take)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_take && sample_valid)
        begin
            s1_setpoint_reg <= setpoint;
            s1_feedback_reg <= feedback;
        end
        if (s1_move)
        begin
            s2_prod_p_reg   <= prod_p_next;
            s2_prod_i_reg   <= prod_i_next;
            s2_prod_d_reg   <= prod_d_next;
            s2_feedback_reg <= s1_feedback_reg;
        end
        if (s2_move)
        begin
            s3_sum_reg      <= sum_next;
            s3_feedback_reg <= s2_feedback_reg;
        end
        if (out_take && s3_valid_reg)
        begin
            out_command_reg <= command_next;
            out_pwm_reg     <= pwm_next;
            out_estop_reg   <= estop_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign command        = out_command_reg;
    assign drive_pwm      = out_pwm_reg;
    assign emergency_stop = out_estop_reg;

endmodule

[rtl/pfd_checker.sv]
`timescale 1ns / 1ps

module pfd_checker
    import pfd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic signed [SAMPLE_W-1:0]   command,
    input  logic signed [PWM_W-1:0]      drive_pwm,
    input  logic                         emergency_stop
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(command) && $stable(drive_pwm) && $stable(emergency_stop))
        else $error("result payload changed while stalled");

    // An emergency stop forces both the command and the PWM value to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && emergency_stop |-> command == '0 && drive_pwm == '0)
        else $error("emergency stop with nonzero output");

    // The PWM value is the scaled command: nonzero only with a nonzero
    // command, and negative only with a negative command.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && drive_pwm != '0 |->
            command != '0 && (drive_pwm[PWM_W-1] == 1'b0 || command[SAMPLE_W-1] == 1'b1))
        else $error("PWM value disagrees with command");

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (.*);
